@@ hdl/tgb_pkg.sv @@
// Package for the tiled glyph blitter: payload words, row setup record, constants.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tgb_pkg;

    // pixels per glyph row, one lane per pixel
    localparam int LANES     = 16;
    localparam int PIX_W     = 4;
    localparam int ADDR_W    = 15;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_HEIGHT = 2'd1;

    typedef struct packed {
        logic [3:0]            glyph_row;
        logic [LANES*PIX_W-1:0] row_pixels;
        logic [4:0]            glyph_width;
        logic [4:0]            glyph_height;
        logic [7:0]            left_x;
        logic [7:0]            top_y;
    } t_in_word;

    typedef struct packed {
        logic [ADDR_W-1:0] byte_address;
        logic              upper_nibble;
        logic [PIX_W-1:0]  pixel_value;
        logic              last_write;
    } t_out_word;

    // registered row setup handed to the lanes and the merge stage
    typedef struct packed {
        logic                   valid;
        logic [ADDR_W-1:0]      base;
        logic [7:0]             left_x;
        logic [LANES*PIX_W-1:0] pixels;
        logic [LANES-1:0]       mask;
    } t_row_setup;

endpackage

@@ hdl/tiled_glyph_blit.sv @@
// Top level of the tiled 4bpp glyph row blitter.
// Instantiates tgb_row_setup, sixteen tgb_lane and tgb_merge; depends on tgb_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word) takes one glyph row
//   per word. Output channel (o_out_valid / i_out_stall / o_out_word) gives
//   one nibble write per word, left to right, last_write set on the final
//   write of a row. Rows that are clipped away or fully transparent give
//   no words at all.
//   Configuration (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
//   sets window width and height in tiles; write only while idle.
//   A taken row passes through the setup register, the row buffer and the
//   output register before its first write. Throughput: one write per cycle
//   while the receiver does not stall; a row holds the row buffer until its
//   opaque visible pixels (up to 16) are written. Setup stage and row buffer
//   overlap, so the next row is taken while the current one drains.
//   Reset: synchronous, active low; pipeline empties, window returns to
//   1 x 1 tiles. When the receiver stalls, the output word holds and the
//   pipeline fills, then o_in_stall rises.
`timescale 1ns / 1ps

module tiled_glyph_blit
    import tgb_pkg::*;
#(
    parameter int MAX_WINDOW_TILES = 32,
    parameter int GLYPH_SIZE       = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // row input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_word             i_in_word,
    // write output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_word            o_out_word,
    // configuration
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0] r_win_width, r_win_height;

    t_row_setup                   w_setup;
    logic                         w_take;
    logic [LANES-1:0][ADDR_W-1:0] w_lane_addr;
    logic [LANES-1:0]             w_lane_upper;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_width  <= CFG_W'(1);
            r_win_height <= CFG_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WIN_WIDTH:  r_win_width  <= i_cfg_data;
                CFG_WIN_HEIGHT: r_win_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tgb_row_setup #(
        .MAX_WINDOW_TILES (MAX_WINDOW_TILES),
        .GLYPH_SIZE       (GLYPH_SIZE)
    ) u_setup (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .i_win_width  (r_win_width),
        .i_win_height (r_win_height),
        .i_take       (w_take),
        .o_setup      (w_setup)
    );

    // one lane per pixel column
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        tgb_lane u_lane (
            .i_lane   (4'(k)),
            .i_base   (w_setup.base),
            .i_left_x (w_setup.left_x),
            .o_addr   (w_lane_addr[k]),
            .o_upper  (w_lane_upper[k])
        );
    end

    tgb_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_setup      (w_setup),
        .i_lane_addr  (w_lane_addr),
        .i_lane_upper (w_lane_upper),
        .o_take       (w_take),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_word   (o_out_word)
    );

    // a transparent pixel never produces a write
    a_opaque_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.pixel_value != '0))
        else $error("write with transparent pixel value");

    // input stalls only while the setup stage holds a row
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> w_setup.valid)
        else $error("input stalled with empty setup stage");

    // output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid after reset");

endmodule

@@ hdl/tgb_row_setup.sv @@
// Row setup stage: clipping, row base address and per-lane write mask.
// Depends on tgb_pkg.
`timescale 1ns / 1ps

module tgb_row_setup
    import tgb_pkg::*;
#(
    parameter int MAX_WINDOW_TILES = 32,
    parameter int GLYPH_SIZE       = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in_word,
    input  logic [CFG_W-1:0] i_win_width,
    input  logic [CFG_W-1:0] i_win_height,
    input  logic             i_take,
    output t_row_setup       o_setup
);

    logic              r_valid;
    logic [ADDR_W-1:0] r_base;
    logic [7:0]        r_left_x;
    logic [LANES*PIX_W-1:0] r_pixels;
    logic [LANES-1:0]  r_mask;

    logic [ADDR_W-1:0] n_base;
    logic [LANES-1:0]  n_mask;

    logic [6:0]         w_stride, w_tiles_h;
    logic [4:0]         w_gw, w_gh;
    logic signed [10:0] w_room_w, w_room_h, w_vis_w, w_vis_h;
    logic               w_row_ok;
    logic [8:0]         w_y;
    logic [12:0]        w_tile_row_off;
    logic               w_accept;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = r_valid && !i_take;

    // saturate window and glyph sizes
    assign w_stride  = ({1'b0, i_win_width} > 7'(MAX_WINDOW_TILES)) ?
                       7'(MAX_WINDOW_TILES) : {1'b0, i_win_width};
    assign w_tiles_h = ({1'b0, i_win_height} > 7'(MAX_WINDOW_TILES)) ?
                       7'(MAX_WINDOW_TILES) : {1'b0, i_win_height};
    assign w_gw = (i_in_word.glyph_width > 5'(GLYPH_SIZE)) ?
                  5'(GLYPH_SIZE) : i_in_word.glyph_width;
    assign w_gh = (i_in_word.glyph_height > 5'(GLYPH_SIZE)) ?
                  5'(GLYPH_SIZE) : i_in_word.glyph_height;

    // clipped extents, may go negative
    assign w_room_w = $signed({1'b0, w_stride, 3'b000}) - $signed({3'b000, i_in_word.left_x});
    assign w_room_h = $signed({1'b0, w_tiles_h, 3'b000}) - $signed({3'b000, i_in_word.top_y});
    assign w_vis_w  = (w_room_w < $signed({6'd0, w_gw})) ? w_room_w : $signed({6'd0, w_gw});
    assign w_vis_h  = (w_room_h < $signed({6'd0, w_gh})) ? w_room_h : $signed({6'd0, w_gh});

    assign w_row_ok = (w_vis_w > 11'sd0) && (w_vis_h > 11'sd0)
                   && ({1'b0, i_in_word.glyph_row} < 5'(GLYPH_SIZE))
                   && ($signed({7'd0, i_in_word.glyph_row}) < w_vis_h);

    // row base: tile row times stride times 32, plus 4 bytes per pixel row
    assign w_y            = {1'b0, i_in_word.top_y} + {5'd0, i_in_word.glyph_row};
    assign w_tile_row_off = 13'(w_y[8:3] * w_stride);
    assign n_base = ADDR_W'({w_tile_row_off, 5'b00000}) + ADDR_W'({w_y[2:0], 2'b00});

    // lane is written when visible and opaque
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_mask[k] = w_row_ok && ($signed(11'(k)) < w_vis_w)
                     && (i_in_word.row_pixels[k*PIX_W +: PIX_W] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_base   <= n_base;
            r_left_x <= i_in_word.left_x;
            r_pixels <= i_in_word.row_pixels;
            r_mask   <= n_mask;
        end
    end

    assign o_setup.valid  = r_valid;
    assign o_setup.base   = r_base;
    assign o_setup.left_x = r_left_x;
    assign o_setup.pixels = r_pixels;
    assign o_setup.mask   = r_mask;

endmodule

@@ hdl/tgb_lane.sv @@
// One pixel lane: byte address and nibble select for one column of the row.
// Depends on tgb_pkg.
`timescale 1ns / 1ps

module tgb_lane
    import tgb_pkg::*;
(
    input  logic [3:0]        i_lane,
    input  logic [ADDR_W-1:0] i_base,
    input  logic [7:0]        i_left_x,
    output logic [ADDR_W-1:0] o_addr,
    output logic              o_upper
);

    logic [8:0] w_x;

    // x = left_x + lane; byte within pixel row, then 32 bytes per tile column
    assign w_x     = {1'b0, i_left_x} + {5'd0, i_lane};
    assign o_addr  = i_base + ADDR_W'(w_x[2:1]) + ADDR_W'({w_x[8:3], 5'b00000});
    assign o_upper = w_x[0];

endmodule

@@ hdl/tgb_merge.sv @@
// Merge stage: holds one row of lane results and emits the opaque ones in column
// order, one word per cycle when not stalled, via an output register; uses tgb_pkg.
`timescale 1ns / 1ps

module tgb_merge
    import tgb_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_row_setup                    i_setup,
    input  logic [LANES-1:0][ADDR_W-1:0]  i_lane_addr,
    input  logic [LANES-1:0]              i_lane_upper,
    output logic                          o_take,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output t_out_word                     o_out_word
);

    logic [LANES-1:0]             r_pend, n_pend;
    logic [LANES-1:0][ADDR_W-1:0] r_addr;
    logic [LANES-1:0]             r_upper;
    logic [LANES-1:0][PIX_W-1:0]  r_val;
    logic                         r_out_valid;
    t_out_word                    r_out;

    logic             w_out_free, w_emit;
    logic [LANES-1:0] w_pick, w_pend_after;
    logic [3:0]       w_idx;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_emit     = (r_pend != '0) && w_out_free;

    // lowest pending column first
    assign w_pick = r_pend & (~r_pend + LANES'(1));
    always_comb begin
        w_idx = '0;
        for (int i = 0; i < LANES; i++) begin
            if (w_pick[i]) begin
                w_idx = 4'(i);
            end
        end
    end

    assign w_pend_after = w_emit ? (r_pend & ~w_pick) : r_pend;
    assign o_take       = (w_pend_after == '0);

    always_comb begin
        n_pend = w_pend_after;
        if (i_setup.valid && o_take) begin
            n_pend = i_setup.mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (w_out_free) begin
                r_out_valid <= w_emit;
            end
        end
    end

    // row buffer load
    always_ff @(posedge i_clk) begin
        if (i_setup.valid && o_take) begin
            r_addr  <= i_lane_addr;
            r_upper <= i_lane_upper;
            r_val   <= i_setup.pixels;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.byte_address <= r_addr[w_idx];
            r_out.upper_nibble <= r_upper[w_idx];
            r_out.pixel_value  <= r_val[w_idx];
            r_out.last_write   <= (w_pend_after == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for tiled_glyph_blit: directed glyph rows, then random rows
// under several window sizes, checked against a nibble write predictor. Depends on tgb_pkg.
`timescale 1ns / 1ps

module testbench;
    import tgb_pkg::*;

    localparam int MAX_TILES   = 32;
    localparam int GLYPH_MAX   = 16;
    localparam int CLK_HALF    = 5;
    localparam int RESET_CYC   = 12;
    localparam int SETTLE_CYC  = 24;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_ROWS  = 60;
    localparam int CALM_FIRST  = 150;
    localparam int CALM_LAST   = 260;

    // one step of the directed plan: a window change or a glyph row
    typedef struct {
        bit               set_cfg;
        logic [CFG_W-1:0] cfg_w;
        logic [CFG_W-1:0] cfg_h;
        t_in_word         word;
        bit               typed;
        int               n_typed;
        t_out_word        typed_write;
    } t_plan_step;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    t_in_word             in_word;
    logic                 out_valid;
    logic                 out_stall;
    t_out_word            out_word;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // window registers as the block should hold them
    logic [CFG_W-1:0] win_tiles_w;
    logic [CFG_W-1:0] win_tiles_h;

    t_out_word  expected_writes[$];
    t_plan_step glyph_plan[$];
    int         errors = 0;
    int         cycles = 0;
    bit         calm   = 1'b0;

    tiled_glyph_blit #(
        .MAX_WINDOW_TILES(MAX_TILES),
        .GLYPH_SIZE(GLYPH_MAX)
    ) u_top (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_word(in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word(out_word),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tiled_glyph_blit regression: fail");
            $finish;
        end
    end

    // receiver stalls at random, except in the calm stretch
    always @(negedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < 9);
    end

    // compare each accepted write word with the oldest expectation
    always @(posedge clk) begin : check_writes
        t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_writes.size() == 0) begin
                $display("%0t: unexpected write: actual addr=%h upper=%b value=%h last=%b",
                         $time, out_word.byte_address, out_word.upper_nibble,
                         out_word.pixel_value, out_word.last_write);
                errors++;
            end else begin
                want = expected_writes.pop_front();
                if (out_word.byte_address !== want.byte_address ||
                    out_word.upper_nibble !== want.upper_nibble ||
                    out_word.pixel_value !== want.pixel_value ||
                    out_word.last_write !== want.last_write) begin
                    $display("%0t: write mismatch: expected addr=%h upper=%b value=%h last=%b",
                             $time, want.byte_address, want.upper_nibble,
                             want.pixel_value, want.last_write);
                    $display("%0t:                 actual   addr=%h upper=%b value=%h last=%b",
                             $time, out_word.byte_address, out_word.upper_nibble,
                             out_word.pixel_value, out_word.last_write);
                    errors++;
                end
            end
        end
    end

    // nibble writes caused by one glyph row under the current window
    function automatic void blit_row_writes(input t_in_word w);
        t_out_word row_writes[$];
        t_out_word one;
        int tiles_w, tiles_h, size_w, size_h, vis_w, vis_h, x, y, base;
        logic [PIX_W-1:0] nib;
        tiles_w = (win_tiles_w > MAX_TILES) ? MAX_TILES : int'(win_tiles_w);
        tiles_h = (win_tiles_h > MAX_TILES) ? MAX_TILES : int'(win_tiles_h);
        size_w  = (w.glyph_width > GLYPH_MAX) ? GLYPH_MAX : int'(w.glyph_width);
        size_h  = (w.glyph_height > GLYPH_MAX) ? GLYPH_MAX : int'(w.glyph_height);
        vis_w   = tiles_w * 8 - int'(w.left_x);
        vis_h   = tiles_h * 8 - int'(w.top_y);
        if (size_w < vis_w) vis_w = size_w;
        if (size_h < vis_h) vis_h = size_h;
        // clipped away, or row below the visible part
        if (vis_w <= 0 || vis_h <= 0 || int'(w.glyph_row) >= vis_h) return;
        y    = int'(w.top_y) + int'(w.glyph_row);
        base = (((y >> 3) * tiles_w) << 5) + ((y & 7) << 2);
        for (int k = 0; k < vis_w && k < LANES; k++) begin
            nib = w.row_pixels[PIX_W*k +: PIX_W];
            if (nib != '0) begin
                x = int'(w.left_x) + k;
                one.byte_address = ADDR_W'(base + ((x >> 1) & 3) + ((x >> 3) << 5));
                one.upper_nibble = x[0];
                one.pixel_value  = nib;
                one.last_write   = 1'b0;
                row_writes.push_back(one);
            end
        end
        if (row_writes.size() > 0) row_writes[row_writes.size()-1].last_write = 1'b1;
        foreach (row_writes[i]) expected_writes.push_back(row_writes[i]);
    endfunction

    function automatic t_in_word glyph_word(input logic [3:0] row, input logic [63:0] pix,
                                            input logic [4:0] gw, input logic [4:0] gh,
                                            input logic [7:0] lx, input logic [7:0] ty);
        t_in_word w;
        w.glyph_row    = row;
        w.row_pixels   = pix;
        w.glyph_width  = gw;
        w.glyph_height = gh;
        w.left_x       = lx;
        w.top_y        = ty;
        return w;
    endfunction

    // random row: mostly placed inside the window, some pure noise
    function automatic t_in_word random_glyph_row();
        t_in_word w;
        int span_w, span_h, density;
        w.row_pixels = {$urandom, $urandom};
        if ($urandom_range(99) < 20) begin
            w.glyph_row    = 4'($urandom);
            w.glyph_width  = 5'($urandom);
            w.glyph_height = 5'($urandom);
            w.left_x       = 8'($urandom);
            w.top_y        = 8'($urandom);
            return w;
        end
        span_w  = 8 * ((win_tiles_w == 0) ? 1 : (win_tiles_w > MAX_TILES) ? MAX_TILES
                                                                          : int'(win_tiles_w));
        span_h  = 8 * ((win_tiles_h == 0) ? 1 : (win_tiles_h > MAX_TILES) ? MAX_TILES
                                                                          : int'(win_tiles_h));
        density = $urandom_range(100);
        for (int k = 0; k < LANES; k++)
            w.row_pixels[PIX_W*k +: PIX_W] =
                ($urandom_range(99) < density) ? 4'($urandom_range(15, 1)) : 4'd0;
        w.glyph_width  = 5'($urandom_range(GLYPH_MAX, 1));
        w.glyph_height = 5'($urandom_range(GLYPH_MAX, 1));
        w.glyph_row    = 4'($urandom_range(int'(w.glyph_height) - 1, 0));
        w.left_x       = 8'($urandom_range((span_w > 256 ? 256 : span_w) - 1, 0));
        w.top_y        = 8'($urandom_range((span_h > 256 ? 256 : span_h) - 1, 0));
        // push some glyphs against the right and bottom edges
        if ($urandom_range(3) == 0) begin
            span_w = span_w - $urandom_range(GLYPH_MAX, 1);
            w.left_x = 8'((span_w < 0) ? 0 : (span_w > 255) ? 255 : span_w);
        end
        if ($urandom_range(3) == 0) begin
            span_h = span_h - $urandom_range(GLYPH_MAX, 1);
            w.top_y = 8'((span_h < 0) ? 0 : (span_h > 255) ? 255 : span_h);
        end
        return w;
    endfunction

    function automatic void plan_row(input t_in_word w, input bit typed, input int n,
                                     input t_out_word res);
        t_plan_step s;
        s.set_cfg     = 1'b0;
        s.cfg_w       = '0;
        s.cfg_h       = '0;
        s.word        = w;
        s.typed       = typed;
        s.n_typed     = n;
        s.typed_write = res;
        glyph_plan.push_back(s);
    endfunction

    function automatic void plan_window(input logic [CFG_W-1:0] tw, input logic [CFG_W-1:0] th);
        t_plan_step s;
        s.set_cfg     = 1'b1;
        s.cfg_w       = tw;
        s.cfg_h       = th;
        s.word        = '0;
        s.typed       = 1'b0;
        s.n_typed     = 0;
        s.typed_write = '0;
        glyph_plan.push_back(s);
    endfunction

    // offer one row word, with a random gap first; record expectations on acceptance
    task automatic send_row(input t_in_word w, input bit typed, input int n,
                            input t_out_word res);
        while (!calm && $urandom_range(99) < 9) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        if (!typed) blit_row_writes(w);
        else if (n > 0) expected_writes.push_back(res);
    endtask

    // stop offering rows and let every expected write come out
    task automatic drain_rows();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_writes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_WIN_WIDTH) win_tiles_w = data;
        else if (idx == CFG_WIN_HEIGHT) win_tiles_h = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] phase_w[PHASES];
        logic [CFG_W-1:0] phase_h[PHASES];
        int               row_count;
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_word     = '0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_WIN_WIDTH;
        cfg_data    = '0;
        win_tiles_w = 6'd1;
        win_tiles_h = 6'd1;
        row_count   = 0;
        repeat (RESET_CYC) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // 1 x 1 tile window after reset
        plan_row(glyph_word(4'd0, 64'h1, 5'd1, 5'd1, 8'd0, 8'd0), 1'b1, 1,
                 t_out_word'{15'd0, 1'b0, 4'd1, 1'b1});
        plan_row(glyph_word(4'd0, 64'hF0, 5'd2, 5'd1, 8'd0, 8'd0), 1'b1, 1,
                 t_out_word'{15'd0, 1'b1, 4'hF, 1'b1});
        // fully transparent row
        plan_row(glyph_word(4'd0, 64'h0, 5'd16, 5'd16, 8'd0, 8'd0), 1'b1, 0, '0);
        // left or top edge outside the window
        plan_row(glyph_word(4'd0, '1, 5'd16, 5'd16, 8'd8, 8'd0), 1'b1, 0, '0);
        plan_row(glyph_word(4'd0, '1, 5'd16, 5'd16, 8'd0, 8'd8), 1'b1, 0, '0);
        // empty glyph
        plan_row(glyph_word(4'd0, '1, 5'd0, 5'd16, 8'd0, 8'd0), 1'b1, 0, '0);
        plan_row(glyph_word(4'd0, '1, 5'd16, 5'd0, 8'd0, 8'd0), 1'b1, 0, '0);
        // row below the clipped height
        plan_row(glyph_word(4'd15, '1, 5'd16, 5'd16, 8'd0, 8'd0), 1'b1, 0, '0);
        plan_row(glyph_word(4'd7, '1, 5'd16, 5'd16, 8'd0, 8'd0), 1'b0, 0, '0);
        // oversized glyph saturates
        plan_row(glyph_word(4'd3, 64'h1234_5678_9ABC_DEF0, 5'd31, 5'd31, 8'd1, 8'd2),
                 1'b0, 0, '0);
        // largest window, far corner
        plan_window(6'd32, 6'd32);
        plan_row(glyph_word(4'd15, '1, 5'd16, 5'd16, 8'd240, 8'd240), 1'b0, 0, '0);
        plan_row(glyph_word(4'd0, 64'h5A5A_A5A5_0F0F_F0F0, 5'd16, 5'd16, 8'd250, 8'd255),
                 1'b0, 0, '0);
        plan_row(glyph_word(4'd1, '1, 5'd16, 5'd16, 8'd0, 8'd255), 1'b1, 0, '0);
        plan_row(glyph_word(4'd0, 64'hFEDC_BA98_7654_3210, 5'd16, 5'd16, 8'd255, 8'd0),
                 1'b0, 0, '0);
        plan_row(glyph_word(4'd0, 64'hFEDC_BA98_7654_3210, 5'd16, 5'd16, 8'd0, 8'd0),
                 1'b0, 0, '0);
        // zero-size window writes nothing
        plan_window(6'd0, 6'd0);
        plan_row(glyph_word(4'd0, '1, 5'd16, 5'd16, 8'd0, 8'd0), 1'b1, 0, '0);
        // register values past the maximum saturate
        plan_window(6'd63, 6'd63);
        plan_row(glyph_word(4'd15, '1, 5'd16, 5'd16, 8'd240, 8'd240), 1'b0, 0, '0);
        plan_window(6'd2, 6'd1);
        plan_row(glyph_word(4'd5, '1, 5'd16, 5'd16, 8'd0, 8'd3), 1'b1, 0, '0);
        plan_row(glyph_word(4'd4, '1, 5'd16, 5'd16, 8'd3, 8'd3), 1'b0, 0, '0);

        foreach (glyph_plan[i]) begin
            if (glyph_plan[i].set_cfg) begin
                drain_rows();
                write_reg(CFG_WIN_WIDTH, glyph_plan[i].cfg_w);
                write_reg(CFG_WIN_HEIGHT, glyph_plan[i].cfg_h);
            end else begin
                send_row(glyph_plan[i].word, glyph_plan[i].typed, glyph_plan[i].n_typed,
                         glyph_plan[i].typed_write);
            end
        end

        // random phases, each under its own window
        phase_w = '{6'd32, 6'd0, 6'd63, 6'd5, 6'd1, 6'd32, 6'd0, 6'd0};
        phase_h = '{6'd32, 6'd7, 6'd63, 6'd3, 6'd32, 6'd1, 6'd0, 6'd0};
        phase_w[PHASES-2] = 6'($urandom);
        phase_h[PHASES-2] = 6'($urandom);
        phase_w[PHASES-1] = 6'($urandom_range(MAX_TILES, 1));
        phase_h[PHASES-1] = 6'($urandom_range(MAX_TILES, 1));
        for (int p = 0; p < PHASES; p++) begin
            drain_rows();
            write_reg(CFG_WIN_WIDTH, phase_w[p]);
            write_reg(CFG_WIN_HEIGHT, phase_h[p]);
            // unused register indexes must leave the window alone
            if (p == 3) begin
                write_reg(CFG_IDX_W'(2), 6'($urandom));
                write_reg(CFG_IDX_W'(3), 6'($urandom));
            end
            for (int r = 0; r < PHASE_ROWS; r++) begin
                calm = (row_count >= CALM_FIRST) && (row_count < CALM_LAST);
                send_row(random_glyph_row(), 1'b0, 0, '0);
                row_count++;
            end
        end
        calm = 1'b0;

        drain_rows();
        if (errors == 0) begin
            $display("tiled_glyph_blit regression: pass");
        end else begin
            $display("tiled_glyph_blit regression: fail");
        end
        $finish;
    end

endmodule

@@ tiled_glyph_blit.f @@
hdl/tgb_pkg.sv
hdl/tgb_row_setup.sv
hdl/tgb_lane.sv
hdl/tgb_merge.sv
hdl/tiled_glyph_blit.sv
verif/testbench.sv
